FILE: sv/prst_pkg.sv
// Package for the probe-request station table: payload structs, status and
// action codes, OUI constants and the OS class function.
// No dependencies.
package prst_pkg;

  typedef enum logic [1:0] {
    ACT_FRAME = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    STAT_IGNORED    = 3'd0,
    STAT_UPDATED    = 3'd1,
    STAT_ADDED      = 3'd2,
    STAT_FULL       = 3'd3,
    STAT_READ_OK    = 3'd4,
    STAT_READ_EMPTY = 3'd5,
    STAT_CLEARED    = 3'd6,
    STAT_RSVD       = 3'd7
  } status_e;

  localparam logic [2:0] OS_UNKNOWN   = 3'd0;
  localparam logic [2:0] OS_RAND_FEW  = 3'd1;
  localparam logic [2:0] OS_RAND_MANY = 3'd2;
  localparam logic [2:0] OS_DESKTOP   = 3'd3;
  localparam logic [2:0] OS_EMBEDDED  = 3'd4;

  localparam logic [7:0]  FC_TYPE_MASK   = 8'hFC;
  localparam logic [7:0]  FC_PROBE_REQ   = 8'h40;
  localparam logic [11:0] MIN_FRAME_LEN  = 12'd16;
  localparam logic [15:0] PROBE_MAX      = 16'hFFFF;
  localparam int unsigned LOCAL_ADMIN_BIT = 41;

  localparam logic [23:0] OUI_DESK_0 = 24'h001B21;
  localparam logic [23:0] OUI_DESK_1 = 24'h001E67;
  localparam logic [23:0] OUI_DESK_2 = 24'h8CEC4B;
  localparam logic [23:0] OUI_DESK_3 = 24'hA4C3F0;
  localparam logic [23:0] OUI_DESK_4 = 24'h00E04C;
  localparam logic [23:0] OUI_DESK_5 = 24'h48022A;
  localparam logic [23:0] OUI_EMB_0  = 24'hB827EB;
  localparam logic [23:0] OUI_EMB_1  = 24'hDCA632;
  localparam logic [23:0] OUI_EMB_2  = 24'hE45F01;

  typedef struct packed {
    action_e            action;
    logic               is_management;
    logic [7:0]         frame_control;
    logic [11:0]        frame_length;
    logic [47:0]        source_mac;
    logic signed [7:0]  signal_dbm;
    logic [5:0]         entry_select;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [5:0]         entry_index;
    logic [47:0]        entry_mac;
    logic [15:0]        probe_total;
    logic signed [7:0]  entry_signal;
    logic [2:0]         os_class;
    logic               is_randomized;
    logic [6:0]         station_count;
  } rsp_t;

  // one table row
  typedef struct packed {
    logic [47:0]        mac;
    logic [15:0]        probes;
    logic signed [7:0]  signal;
    logic [2:0]         os_class;
  } entry_t;

  function automatic logic [2:0] classify_os(logic [47:0] mac, logic [15:0] probes,
                                             logic [7:0] max_few);
    logic [23:0] oui;
    logic [2:0]  cls;
    oui = mac[47:24];
    cls = OS_UNKNOWN;
    if (mac[LOCAL_ADMIN_BIT]) begin
      cls = (probes <= {8'd0, max_few}) ? OS_RAND_FEW : OS_RAND_MANY;
    end else begin
      case (oui)
        OUI_DESK_0, OUI_DESK_1, OUI_DESK_2,
        OUI_DESK_3, OUI_DESK_4, OUI_DESK_5: cls = OS_DESKTOP;
        OUI_EMB_0, OUI_EMB_1, OUI_EMB_2:    cls = OS_EMBEDDED;
        default:                            cls = OS_UNKNOWN;
      endcase
    end
    return cls;
  endfunction

endpackage

FILE: sv/probe_request_station_table_core.sv
// Probe-request station table, top level: sequencer, station memory,
// shared MAC comparator and result register.
// Depends on prst_pkg.
//
// Usage
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one transaction per
//   item: a captured frame, a read of one entry, or a table clear.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   result transaction per item. Config channel (cfg_valid_i/cfg_ready_o/
//   cfg_data_i) writes the randomised-MAC probe threshold; always ready.
// Sequencing
//   One item at a time; in_ready_o is high only when the sequencer is idle.
//   Probe request: an accept state, a decode state, a scan of the stored
//   stations (one memory read a cycle through the single read port), then an
//   update or add that writes the row, or a full-table result. A read goes
//   through decode and a read-wait state; an ignored frame or a clear is
//   answered from decode.
// Reset
//   Station count cleared, threshold back to 3, no result pending. Station
//   memory is not cleared; only rows below the count are ever read.
// Back-pressure
//   A finished result sits in the output register. A new item is taken
//   while it waits; the next result (and its memory write) holds until the
//   output register frees up.
module probe_request_station_table_core
  import prst_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_data_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(TABLE_ENTRIES);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_UPDATE = 6'b001000,
    ST_ADD    = 6'b010000,
    ST_RDWAIT = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  req_t            in_q;
  logic [7:0]      max_few_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  logic            out_valid_q;
  rsp_t            out_data_q;

  // station memory: one write port, one registered read port
  entry_t          mem [TABLE_ENTRIES];
  entry_t          rd_data_q;
  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  entry_t          wr_data;

  logic            emit;
  rsp_t            res;
  logic            out_free;
  logic            is_probe;
  logic            sel_in_range;
  logic            more;
  logic            hit;
  logic [15:0]     new_probes;
  logic [31:0]     count_ext;

  function automatic rsp_t entry_result(status_e st, logic [31:0] idx, entry_t e);
    rsp_t r;
    r               = '0;
    r.status        = st;
    r.entry_index   = idx[5:0];
    r.entry_mac     = e.mac;
    r.probe_total   = e.probes;
    r.entry_signal  = e.signal;
    r.os_class      = e.os_class;
    r.is_randomized = e.mac[LOCAL_ADMIN_BIT];
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign is_probe = in_q.is_management && (in_q.frame_length >= MIN_FRAME_LEN) &&
                    ((in_q.frame_control & FC_TYPE_MASK) == FC_PROBE_REQ);
  assign sel_in_range = (32'(in_q.entry_select) < 32'(count_q)) &&
                        (32'(in_q.entry_select) < 32'(TABLE_ENTRIES));
  assign more       = issue_q < count_q;
  // the one MAC comparator, reused for every stored station
  assign hit        = cmp_vld_q && (rd_data_q.mac == in_q.source_mac);
  assign new_probes = (rd_data_q.probes == PROBE_MAX) ? rd_data_q.probes
                                                      : rd_data_q.probes + 16'd1;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    issue_d   = issue_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    emit      = 1'b0;
    res       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (in_q.action)
          ACT_FRAME: begin
            if (is_probe) begin
              issue_d = '0;
              state_d = ST_SCAN;
            end else if (out_free) begin
              emit       = 1'b1;
              res.status = STAT_IGNORED;
              state_d    = ST_IDLE;
            end
          end
          ACT_READ: begin
            if (sel_in_range) begin
              rd_en   = 1'b1;
              rd_addr = IdxW'(in_q.entry_select);
              state_d = ST_RDWAIT;
            end else if (out_free) begin
              emit            = 1'b1;
              res.status      = STAT_READ_EMPTY;
              res.entry_index = in_q.entry_select;
              state_d         = ST_IDLE;
            end
          end
          ACT_CLEAR: begin
            if (out_free) begin
              emit       = 1'b1;
              res.status = STAT_CLEARED;
              count_d    = '0;
              state_d    = ST_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              emit       = 1'b1;
              res.status = STAT_IGNORED;
              state_d    = ST_IDLE;
            end
          end
        endcase
      end
      ST_SCAN: begin
        // read one row a cycle, compare the row read the cycle before
        if (hit) begin
          state_d = ST_UPDATE;
        end else if (more) begin
          rd_en     = 1'b1;
          rd_addr   = issue_q[IdxW-1:0];
          issue_d   = issue_q + CntW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[IdxW-1:0];
        end else if (!cmp_vld_q) begin
          if (count_q != CntFull) begin
            state_d = ST_ADD;
          end else if (out_free) begin
            emit       = 1'b1;
            res.status = STAT_FULL;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          wr_en            = 1'b1;
          wr_addr          = cmp_idx_q;
          wr_data.mac      = rd_data_q.mac;
          wr_data.probes   = new_probes;
          wr_data.signal   = in_q.signal_dbm;
          wr_data.os_class = classify_os(rd_data_q.mac, new_probes, max_few_q);
          emit             = 1'b1;
          res              = entry_result(STAT_UPDATED, 32'(cmp_idx_q), wr_data);
          state_d          = ST_IDLE;
        end
      end
      ST_ADD: begin
        if (out_free) begin
          wr_en            = 1'b1;
          wr_addr          = count_q[IdxW-1:0];
          wr_data.mac      = in_q.source_mac;
          wr_data.probes   = 16'd1;
          wr_data.signal   = in_q.signal_dbm;
          wr_data.os_class = classify_os(in_q.source_mac, 16'd1, max_few_q);
          count_d          = count_q + CntW'(1);
          emit             = 1'b1;
          res              = entry_result(STAT_ADDED, 32'(count_q), wr_data);
          state_d          = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        if (out_free) begin
          emit    = 1'b1;
          res     = entry_result(STAT_READ_OK, 32'(in_q.entry_select), rd_data_q);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    count_ext         = 32'(count_d);
    res.station_count = count_ext[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      out_valid_q <= 1'b0;
      max_few_q   <= 8'd3;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        max_few_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (emit) begin
      out_data_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/prst_checker.sv
// Port-level checks for the probe-request station table, bound to the top.
// Depends on prst_pkg and probe_request_station_table_core.
module prst_checker
  import prst_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  // one item at a time: busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous item in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_CLEARED |-> out_data_o.station_count == 7'd0)
    else $error("clear left stations behind");

  a_add_first_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_ADDED |->
      out_data_o.probe_total == 16'd1 && out_data_o.station_count != 7'd0)
    else $error("new station without a single probe");

  a_ignored_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_IGNORED |->
      out_data_o.entry_mac == 48'd0 && out_data_o.probe_total == 16'd0 &&
      out_data_o.os_class == OS_UNKNOWN)
    else $error("ignored item carries entry data");

endmodule

bind probe_request_station_table_core prst_checker u_prst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: tb/station_mirror_pkg.sv
// Testbench mirror of the probe-request station table: keeps its own copy
// of the table and threshold, predicts one result per transaction and checks
// results in order. Depends on prst_pkg.
package station_mirror_pkg;
  import prst_pkg::*;

  localparam int unsigned MIRROR_ROWS = 64;

  class station_table_mirror;
    entry_t      rows [MIRROR_ROWS];
    int unsigned held;
    logic [7:0]  few_limit;
    rsp_t        awaited [$];
    int unsigned faults;

    function new();
      held      = 0;
      few_limit = 8'd3;
      faults    = 0;
    endfunction

    function void set_few_limit(logic [7:0] v);
      few_limit = v;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function logic [2:0] guess_os(logic [47:0] mac, logic [15:0] probes);
      if (mac[LOCAL_ADMIN_BIT]) begin
        return (probes <= {8'd0, few_limit}) ? OS_RAND_FEW : OS_RAND_MANY;
      end
      case (mac[47:24])
        OUI_DESK_0, OUI_DESK_1, OUI_DESK_2,
        OUI_DESK_3, OUI_DESK_4, OUI_DESK_5: return OS_DESKTOP;
        OUI_EMB_0, OUI_EMB_1, OUI_EMB_2:    return OS_EMBEDDED;
        default:                            return OS_UNKNOWN;
      endcase
    endfunction

    function rsp_t row_report(status_e st, int unsigned i);
      rsp_t r;
      r               = '0;
      r.status        = st;
      r.entry_index   = 6'(i);
      r.entry_mac     = rows[i].mac;
      r.probe_total   = rows[i].probes;
      r.entry_signal  = rows[i].signal;
      r.os_class      = rows[i].os_class;
      r.is_randomized = rows[i].mac[LOCAL_ADMIN_BIT];
      return r;
    endfunction

    // accepted request: update the table copy and queue the expected result
    function void note_request(req_t q);
      rsp_t        want;
      int unsigned i;
      bit          hit;
      want = '0;
      hit  = 1'b0;
      case (q.action)
        ACT_FRAME: begin
          if (q.is_management && q.frame_length >= MIN_FRAME_LEN &&
              (q.frame_control & FC_TYPE_MASK) == FC_PROBE_REQ) begin
            for (i = 0; i < held; i++) begin
              if (!hit && rows[i].mac == q.source_mac) begin
                if (rows[i].probes != PROBE_MAX) rows[i].probes++;
                rows[i].signal   = q.signal_dbm;
                rows[i].os_class = guess_os(rows[i].mac, rows[i].probes);
                want = row_report(STAT_UPDATED, i);
                hit  = 1'b1;
              end
            end
            if (!hit) begin
              if (held < MIRROR_ROWS) begin
                rows[held].mac      = q.source_mac;
                rows[held].probes   = 16'd1;
                rows[held].signal   = q.signal_dbm;
                rows[held].os_class = guess_os(q.source_mac, 16'd1);
                want = row_report(STAT_ADDED, held);
                held++;
              end else begin
                want.status = STAT_FULL;
              end
            end
          end else begin
            want.status = STAT_IGNORED;
          end
        end
        ACT_READ: begin
          if (q.entry_select < held) begin
            want = row_report(STAT_READ_OK, q.entry_select);
          end else begin
            want.status      = STAT_READ_EMPTY;
            want.entry_index = q.entry_select;
          end
        end
        ACT_CLEAR: begin
          held        = 0;
          want.status = STAT_CLEARED;
        end
        default: want.status = STAT_IGNORED;
      endcase
      want.station_count = 7'(held);
      awaited.insert(awaited.size(), want);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
        faults++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, actual 0x%0h",
                 $time, got);
        faults++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("entry_index", want.entry_index, got.entry_index);
      compare_field("entry_mac", want.entry_mac, got.entry_mac);
      compare_field("probe_total", want.probe_total, got.probe_total);
      compare_field("entry_signal", $unsigned(want.entry_signal), $unsigned(got.entry_signal));
      compare_field("os_class", want.os_class, got.os_class);
      compare_field("is_randomized", want.is_randomized, got.is_randomized);
      compare_field("station_count", want.station_count, got.station_count);
    endfunction
  endclass

endpackage

FILE: tb/testbench.sv
// Top-level testbench for probe_request_station_table_core: drives frames,
// reads and clears, checks every result against the station mirror.
// Depends on prst_pkg and station_mirror_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import prst_pkg::*;
  import station_mirror_pkg::*;

  localparam int unsigned     RANDOM_ITEMS = 1140;
  localparam int unsigned     PHASES       = 5;
  localparam int unsigned     POOL_SIZE    = 96;
  // About 1450 transactions, each at worst a full-table scan plus the worst
  // receiver stall and sender gap: well within this limit.
  localparam longint unsigned CYCLE_LIMIT  = 1_000_000;
  // long enough for a full-table probe scan, so this covers any straggler
  localparam int unsigned     TAIL_CYCLES  = 100;

  localparam logic [23:0] DESK_OUIS [6] = '{OUI_DESK_0, OUI_DESK_1, OUI_DESK_2,
                                            OUI_DESK_3, OUI_DESK_4, OUI_DESK_5};
  localparam logic [23:0] EMB_OUIS  [3] = '{OUI_EMB_0, OUI_EMB_1, OUI_EMB_2};

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;
  logic in_valid  = 1'b0;
  logic in_ready;
  req_t in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  station_table_mirror mirror;

  // pacing controls, changed per phase by the stimulus
  bit              gaps_on    = 1'b1;
  bit              stalls_on  = 1'b1;
  int              burst_left = 0;
  logic [12:0]     stall_word = '1;
  int unsigned     stall_age  = 0;
  longint unsigned cycles     = 0;
  logic [47:0]     mac_pool [POOL_SIZE];

  probe_request_station_table_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure: a 13-bit word rotates onto out_ready, so stalls
  // drift across every phase of the sequencer. When a new word is drawn, a
  // quarter of the time it is all ones, giving stall-free stretches.
  always @(posedge clk_i) begin
    stall_age <= stall_age + 1;
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= stall_word[0];
    end
    if (stall_age % 300 == 299) begin
      stall_word <= ($urandom_range(0, 3) == 0) ? '1 : (13'($urandom) | 13'd1);
    end else begin
      stall_word <= {stall_word[0], stall_word[12:1]};
    end
  end

  // Result monitor: every accepted result transaction goes to the mirror.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) mirror.check_response(out_data);
  end

  // Sender idling: bursts of random length, then a random gap with valid low.
  task automatic pace();
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(0, 20);
      end
    end
  endtask

  // Offer one request and hold it until the block takes it. Valid is left
  // high unless pace() opens a gap, so a following request is offered at once.
  task automatic push(req_t q);
    in_valid <= 1'b1;
    in_data  <= q;
    do @(posedge clk_i); while (!in_ready);
    mirror.note_request(q);
    pace();
  endtask

  // Stop sending and wait until every outstanding result has come back.
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (mirror.outstanding() != 0);
  endtask

  // Threshold write; only ever called with the block idle.
  task automatic write_limit(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    mirror.set_few_limit(v);
    cfg_valid <= 1'b0;
  endtask

  // Station MAC: desktop OUI, embedded OUI, locally administered, or anything.
  function automatic logic [47:0] fresh_mac();
    logic [47:0] m;
    m = {16'($urandom), 32'($urandom)};
    case ($urandom_range(0, 3))
      0: m[47:24] = DESK_OUIS[$urandom_range(0, 5)];
      1: m[47:24] = EMB_OUIS[$urandom_range(0, 2)];
      2: m[LOCAL_ADMIN_BIT] = 1'b1;
      default: ;
    endcase
    return m;
  endfunction

  // Well-formed probe request with random length, RSSI and low control bits.
  function automatic req_t probe(logic [47:0] mac);
    req_t q;
    q.action        = ACT_FRAME;
    q.is_management = 1'b1;
    q.frame_control = FC_PROBE_REQ | 8'($urandom_range(0, 3));
    q.frame_length  = 12'($urandom_range(16, 4095));
    q.source_mac    = mac;
    q.signal_dbm    = 8'($urandom);
    q.entry_select  = 6'($urandom);
    return q;
  endfunction

  function automatic req_t command(action_e act, logic [5:0] sel);
    req_t q;
    q              = probe(fresh_mac());
    q.action       = act;
    q.entry_select = sel;
    return q;
  endfunction

  // Random transaction. Mostly probe requests drawn from a per-phase MAC
  // pool so hits and a full table both happen; then reads, rare clears,
  // malformed frames and raw noise. Malformed and noise ones are flagged as not counted.
  function automatic req_t random_item(output bit counted);
    req_t        q;
    int unsigned roll;
    logic [47:0] m;
    roll    = $urandom_range(0, 999);
    counted = 1'b1;
    m       = ($urandom_range(0, 9) < 8) ? mac_pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : fresh_mac();
    if (roll < 700) begin
      q = probe(m);
    end else if (roll < 850) begin
      q = command(ACT_READ, 6'($urandom));
    end else if (roll < 855) begin
      q = command(ACT_CLEAR, 6'($urandom));
    end else if (roll < 950) begin
      q       = probe(m);
      counted = 1'b0;
      case ($urandom_range(0, 2))
        0: q.is_management = 1'b0;
        1: q.frame_length  = 12'($urandom_range(0, 15));
        default: begin
          q.frame_control = 8'($urandom);
          if ((q.frame_control & FC_TYPE_MASK) == FC_PROBE_REQ) q.frame_control ^= 8'h80;
        end
      endcase
    end else begin
      q               = probe(fresh_mac());
      q.action        = action_e'($urandom_range(0, 3));
      q.is_management = 1'($urandom);
      q.frame_control = 8'($urandom);
      q.frame_length  = 12'($urandom);
      counted         = 1'b0;
    end
    return q;
  endfunction

  initial begin : stimulus
    req_t            q;
    bit              counted;
    int unsigned     done;
    int unsigned     p;
    int unsigned     k;
    logic [47:0]     m;
    logic [47:0]     desk_mac;
    logic [47:0]     rand_mac;
    mirror = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- Directed part, threshold at its reset value of 3 ---
    desk_mac = {OUI_DESK_0, 24'h000001};
    rand_mac = 48'h02AB_CDEF_0123;
    // frames the block must ignore: not management, too short, wrong subtype; then a no-op action
    q = probe(desk_mac); q.is_management = 1'b0;               push(q);
    q = probe(desk_mac); q.frame_length  = 12'd15;             push(q);
    q = probe(desk_mac); q.frame_control = 8'h50;              push(q);
    q = command(ACT_NONE, 6'd0);                               push(q);
    // adds across the OS classes, shortest and longest frames, RSSI extremes
    q = probe(desk_mac); q.frame_length = 12'd16; q.frame_control = FC_PROBE_REQ;
    q.signal_dbm = -8'sd128;                                   push(q);
    q = probe({OUI_EMB_0, 24'hFFFFFF}); q.frame_length = 12'd4095;
    q.frame_control = 8'h43; q.signal_dbm = 8'sd127;           push(q);
    q = probe(rand_mac);                                       push(q);
    q = probe(48'h0);                                          push(q);
    q = probe('1);                                             push(q);
    // randomised MAC crosses the few-probes threshold on repeat hits
    repeat (4) push(probe(rand_mac));
    push(probe(desk_mac));
    push(command(ACT_READ, 6'd0));
    push(command(ACT_READ, 6'd4));
    push(command(ACT_READ, 6'd5));
    push(command(ACT_READ, 6'd63));
    push(command(ACT_CLEAR, 6'd0));
    push(command(ACT_READ, 6'd0));
    push(probe(desk_mac));

    // --- Random phases; the sender drains before each threshold write ---
    for (p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        quiesce();
        case (p)
          1: write_limit(8'd0);
          2: write_limit(8'hFF);
          3: write_limit(8'($urandom_range(1, 254)));
          default: write_limit(8'd1);
        endcase
      end
      // one phase runs flat out on both sides
      gaps_on   = (p != 2);
      stalls_on = (p != 2);
      for (k = 0; k < POOL_SIZE; k++) mac_pool[k] = fresh_mac();
      done = 0;
      while (done < RANDOM_ITEMS / PHASES) begin
        q = random_item(counted);
        push(q);
        if (counted) done++;
      end
    end

    // --- Fill all 64 rows, overflow, then hit the last row ---
    push(command(ACT_CLEAR, 6'd0));
    for (k = 0; k < MIRROR_ROWS; k++) begin
      m       = fresh_mac();
      m[7:0]  = 8'(k);
      push(probe(m));
    end
    q = probe(m); q.source_mac[7:0] = 8'd200;                  push(q);
    push(probe(m));
    push(command(ACT_READ, 6'd63));
    q = probe(m); q.frame_length = 12'd0;                      push(q);

    // --- Repeat hits on a single randomised row, no idling ---
    quiesce();
    write_limit(8'hFF);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    push(command(ACT_CLEAR, 6'd0));
    m = 48'h0A00_0000_BEEF;
    for (k = 0; k < 20; k++) push(probe(m));
    push(command(ACT_READ, 6'd0));

    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mirror.faults == 0 && mirror.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
